FILE: design/union_find_rank_compress_top_macros.svh
// Assertion macros for the disjoint-set engine.
// ASSERT_OFF removes every check.
`ifndef UNION_FIND_RANK_COMPRESS_TOP_MACROS_SVH
`define UNION_FIND_RANK_COMPRESS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define UFRC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define UFRC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define UFRC_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define UFRC_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: design/ufrc_pkg.sv
package ufrc_pkg;

  localparam int ELEM_W = 10;   // element index field
  localparam int CNT_W  = 11;   // element / set count field
  localparam int RANK_W = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_UNION = 1'b1
  } op_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root_index;
    logic              merged;
    logic [CNT_W-1:0]  set_count;
    logic              range_error;
  } res_t;

endpackage

FILE: design/ufrc_if.sv
interface ufrc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ufrc_pkg::ELEM_W-1:0] first_elem;
  logic [ufrc_pkg::ELEM_W-1:0] second_elem;

  modport source (output valid, opcode, first_elem, second_elem, input ready);
  modport sink   (input valid, opcode, first_elem, second_elem, output ready);
endinterface

interface ufrc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ufrc_pkg::ELEM_W-1:0] root_index;
  logic                        merged;
  logic [ufrc_pkg::CNT_W-1:0]  set_count;
  logic                        range_error;

  modport source (output valid, root_index, merged, set_count, range_error, input ready);
  modport sink   (input valid, root_index, merged, set_count, range_error, output ready);
endinterface

FILE: design/union_find_rank_compress_top.sv
// channel   dir  handshake     word
// req       in   valid/ready   opcode, first_elem, second_elem
// rsp       out  valid/ready   root_index, merged, set_count, range_error
// cfg       in   cfg_we        cfg_data -> element_count
//
// One table read and one table write per cycle. A find walks the parent chain to the
// root, then points every node it passed at the root; a union does this for both elements,
// then a link step when the sets differ and a rank bump on a tie; a bad index skips the walk.
// After reset, and after a write that lowers element_count, a clearing pass
// over all MAX_ELEMENTS table entries runs with req.ready low.
// rsp is a registered word; a new request is taken while it waits.
`include "union_find_rank_compress_top_macros.svh"

module union_find_rank_compress_top #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ufrc_pkg::CNT_W-1:0] cfg_data,
  ufrc_req_if.sink                   req,
  ufrc_rsp_if.source                 rsp
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int DW    = ufrc_pkg::RANK_W + IDX_W;

  logic [ufrc_pkg::CNT_W-1:0] element_count;
  logic                       clr_req;
  logic                       start;
  logic                       res_valid;
  logic                       res_take;
  ufrc_pkg::res_t             res;
  logic [IDX_W-1:0]           rd_addr;
  logic [DW-1:0]              rd_data;
  logic                       we;
  logic [IDX_W-1:0]           wr_addr;
  logic [DW-1:0]              wr_data;

  assign clr_req  = cfg_we && (cfg_data < element_count);
  assign start    = req.valid && req.ready;
  assign res_take = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_we) begin
      element_count <= cfg_data;
    end
  end

  ufrc_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .clr_req    (clr_req),
    .ec         (element_count),
    .start      (start),
    .opcode     (req.opcode),
    .first_elem (req.first_elem),
    .second_elem(req.second_elem),
    .ready      (req.ready),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .we         (we),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ufrc_table #(
    .DEPTH(MAX_ELEMENTS),
    .DW   (DW)
  ) u_table (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp.root_index  <= res.root_index;
      rsp.merged      <= res.merged;
      rsp.set_count   <= res.set_count;
      rsp.range_error <= res.range_error;
    end
  end

  `UFRC_ASSERT_NXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready)
  `UFRC_ASSERT_IMP(a_clear_after_reset, clk, rst, $fell(rst), !req.ready)
  `UFRC_ASSERT_IMP(a_error_word_clean, clk, rst, rsp.valid && rsp.range_error, !rsp.merged && (rsp.root_index == '0))

endmodule

FILE: design/ufrc_table.sv
module ufrc_table #(
  parameter int DEPTH = 1024,
  parameter int DW    = 14,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/ufrc_ctrl.sv
module ufrc_ctrl #(
  parameter int MAX_ELEMENTS = 1024,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int DW    = ufrc_pkg::RANK_W + IDX_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr_req,
  input  logic [ufrc_pkg::CNT_W-1:0]  ec,
  input  logic                        start,
  input  logic                        opcode,
  input  logic [ufrc_pkg::ELEM_W-1:0] first_elem,
  input  logic [ufrc_pkg::ELEM_W-1:0] second_elem,
  output logic                        ready,
  output logic                        res_valid,
  input  logic                        res_take,
  output ufrc_pkg::res_t              res,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [DW-1:0]               rd_data,
  output logic                        we,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [DW-1:0]               wr_data
);

  localparam int CW   = ufrc_pkg::CNT_W;
  localparam int EW   = ufrc_pkg::ELEM_W;
  localparam int RW   = ufrc_pkg::RANK_W;
  localparam int NW0  = $clog2(MAX_ELEMENTS + 1);
  localparam int LW   = (NW0 > CW) ? NW0 : CW;
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(MAX_ELEMENTS - 1);
  localparam logic [LW-1:0]    MAX_N = LW'(MAX_ELEMENTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_COMP  = 7'b0001000,
    S_LINK  = 7'b0010000,
    S_BUMP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  clr_idx, clr_idx_next;
  ufrc_pkg::op_t     op_q, op_q_next;
  logic              phase, phase_next;
  logic [IDX_W-1:0]  b_idx, b_idx_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W-1:0]  walk, walk_next;
  logic [IDX_W-1:0]  root, root_next;
  logic [RW-1:0]     root_rank, root_rank_next;
  logic [IDX_W-1:0]  root_a, root_a_next;
  logic [RW-1:0]     rank_a, rank_a_next;
  logic [CW-1:0]     merge_total, merge_total_next;
  logic [IDX_W-1:0]  res_root, res_root_next;
  logic              res_merged, res_merged_next;
  logic              res_err, res_err_next;

  logic [IDX_W-1:0]  rd_par;
  logic [RW-1:0]     rd_rank;
  logic [RW-1:0]     rank_inc;
  logic [LW-1:0]     ec_ext, live_n, mt_ext, sets_w;
  logic              a_bad, b_bad, req_bad;
  logic              fdone;
  logic [IDX_W-1:0]  found_root;
  logic [RW-1:0]     found_rank;

  assign rd_par  = rd_data[IDX_W-1:0];
  assign rd_rank = rd_data[DW-1:IDX_W];
  assign rank_inc = (rank_a == ufrc_pkg::RANK_MAX) ? rank_a : rank_a + 1'b1;

  // effective count is the register clamped to the table size
  assign ec_ext = LW'(ec);
  assign live_n = (ec_ext < MAX_N) ? ec_ext : MAX_N;
  assign mt_ext = LW'(merge_total);
  assign sets_w = (mt_ext <= live_n) ? live_n - mt_ext : '0;

  assign a_bad   = LW'(first_elem) >= live_n;
  assign b_bad   = LW'(second_elem) >= live_n;
  assign req_bad = a_bad || ((ufrc_pkg::op_t'(opcode) == ufrc_pkg::OP_UNION) && b_bad);

  assign ready     = (state == S_IDLE) && !clr_req;
  assign res_valid = (state == S_DONE);

  assign res.root_index  = EW'(res_root);
  assign res.merged      = res_merged;
  assign res.set_count   = CW'(sets_w);
  assign res.range_error = res_err;

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    op_q_next        = op_q;
    phase_next       = phase;
    b_idx_next       = b_idx;
    cur_next         = cur;
    walk_next        = walk;
    root_next        = root;
    root_rank_next   = root_rank;
    root_a_next      = root_a;
    rank_a_next      = rank_a;
    merge_total_next = merge_total;
    res_root_next    = res_root;
    res_merged_next  = res_merged;
    res_err_next     = res_err;
    rd_addr          = cur;
    we               = 1'b0;
    wr_addr          = walk;
    wr_data          = '0;
    fdone            = 1'b0;
    found_root       = cur;
    found_rank       = rd_rank;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_q_next       = ufrc_pkg::op_t'(opcode);
          b_idx_next      = IDX_W'(second_elem);
          cur_next        = IDX_W'(first_elem);
          walk_next       = IDX_W'(first_elem);
          phase_next      = 1'b0;
          res_merged_next = 1'b0;
          res_root_next   = '0;
          res_err_next    = req_bad;
          if (req_bad) begin
            state_next = S_DONE;
          end else begin
            rd_addr    = IDX_W'(first_elem);
            state_next = S_WALK;
          end
        end
      end
      S_CLEAR: begin
        we           = 1'b1;
        wr_addr      = clr_idx;
        wr_data      = {{RW{1'b0}}, clr_idx};
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        // rd_data holds the word of cur; walk still marks the start node
        if (rd_par == cur) begin
          if (walk == cur) begin
            fdone      = 1'b1;
            found_root = cur;
            found_rank = rd_rank;
          end else begin
            root_next      = cur;
            root_rank_next = rd_rank;
            rd_addr        = walk;
            state_next     = S_COMP;
          end
        end else begin
          cur_next = rd_par;
          rd_addr  = rd_par;
        end
      end
      S_COMP: begin
        we        = 1'b1;
        wr_addr   = walk;
        wr_data   = {rd_rank, root};
        walk_next = rd_par;
        if (rd_par == root) begin
          fdone      = 1'b1;
          found_root = root;
          found_rank = root_rank;
        end else begin
          rd_addr = rd_par;
        end
      end
      S_LINK: begin
        we               = 1'b1;
        merge_total_next = merge_total + 1'b1;
        res_merged_next  = 1'b1;
        if (rank_a < root_rank) begin
          wr_addr       = root_a;
          wr_data       = {rank_a, root};
          res_root_next = root;
          state_next    = S_DONE;
        end else begin
          wr_addr       = root;
          wr_data       = {root_rank, root_a};
          res_root_next = root_a;
          state_next    = (rank_a == root_rank) ? S_BUMP : S_DONE;
        end
      end
      S_BUMP: begin
        we         = 1'b1;
        wr_addr    = root_a;
        wr_data    = {rank_inc, root_a};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fdone) begin
      if (!phase) begin
        if (op_q == ufrc_pkg::OP_FIND) begin
          res_root_next = found_root;
          state_next    = S_DONE;
        end else begin
          root_a_next = found_root;
          rank_a_next = found_rank;
          phase_next  = 1'b1;
          cur_next    = b_idx;
          walk_next   = b_idx;
          rd_addr     = b_idx;
          state_next  = S_WALK;
        end
      end else begin
        root_next      = found_root;
        root_rank_next = found_rank;
        if (found_root == root_a) begin
          res_root_next = root_a;
          state_next    = S_DONE;
        end else begin
          state_next = S_LINK;
        end
      end
    end

    // shrinking count: wipe the table back to singletons
    if (clr_req) begin
      state_next       = S_CLEAR;
      clr_idx_next     = '0;
      merge_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      merge_total <= '0;
      phase       <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      merge_total <= merge_total_next;
      phase       <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    b_idx      <= b_idx_next;
    cur        <= cur_next;
    walk       <= walk_next;
    root       <= root_next;
    root_rank  <= root_rank_next;
    root_a     <= root_a_next;
    rank_a     <= rank_a_next;
    res_root   <= res_root_next;
    res_merged <= res_merged_next;
    res_err    <= res_err_next;
  end

endmodule
